// File: rtl/tip_pkg.sv
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types and constants of the piecewise-linear table lookup block.
// ----------------------------------------------------------------------------
package tip_pkg;

    // Default sizing of the breakpoint table and the value format.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed port widths.
    localparam int PORT_VALUE_W = 32;
    localparam int INDEX_W      = 6;
    localparam int NPTS_W       = 7;
    localparam int POS_W        = 7;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // Operation codes of an input transfer.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_NUM_POINTS  = 1'b0,
        REG_CLIP_ENABLE = 1'b1
    } t_reg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_EXACT  = 3'd0,
        ST_INTERP = 3'd1,
        ST_CLIP   = 3'd2,
        ST_EXTRAP = 3'd3,
        ST_SAT    = 3'd4,
        ST_ZSPAN  = 3'd5
    } t_status;

    // One classified command between the front end and the engine.
    typedef struct packed {
        logic                    query;
        logic [INDEX_W-1:0]      idx;
        logic [PORT_VALUE_W-1:0] x;
        logic [PORT_VALUE_W-1:0] y;
    } t_cmd;

    // Configuration register contents.
    typedef struct packed {
        logic [NPTS_W-1:0] num_points;
        logic              clip_enable;
    } t_cfg;

endpackage

// File: rtl/tip_front.sv
// ----------------------------------------------------------------------------
// tip_front
// Front end: configuration registers on the APB port, and classification of
// incoming transfers into load and query commands for the command queue.
// ----------------------------------------------------------------------------
module tip_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tip_pkg::PADDR_W-1:0]       paddr,
    input  logic [tip_pkg::PDATA_W-1:0]       pwdata,
    output logic [tip_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    input  logic                              i_op,
    input  logic [tip_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic signed [tip_pkg::PORT_VALUE_W-1:0] i_x_value,
    input  logic signed [tip_pkg::PORT_VALUE_W-1:0] i_y_value,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output tip_pkg::t_cmd                     o_cmd,
    output tip_pkg::t_cfg                     o_cfg
);
    import tip_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[2]);
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_points  <= NPTS_W'(2);
            r_cfg.clip_enable <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_NUM_POINTS:  r_cfg.num_points  <= pwdata[NPTS_W-1:0];
                REG_CLIP_ENABLE: r_cfg.clip_enable <= pwdata[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_sel)
            REG_NUM_POINTS:  prdata = PDATA_W'(r_cfg.num_points);
            REG_CLIP_ENABLE: prdata = PDATA_W'(r_cfg.clip_enable);
            default:         prdata = '0;
        endcase
    end

    // Classify the transfer and hand it to the queue.
    assign o_push       = i_valid && !i_queue_full;
    assign o_cmd.query  = (t_op'(i_op) == OP_QUERY);
    assign o_cmd.idx    = i_entry_index;
    assign o_cmd.x      = i_x_value;
    assign o_cmd.y      = i_y_value;
    assign o_cfg        = r_cfg;

endmodule

// File: rtl/tip_queue.sv
// ----------------------------------------------------------------------------
// tip_queue
// Two-entry command queue between the front end and the engine.
// ----------------------------------------------------------------------------
module tip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tip_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output tip_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import tip_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_mem [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(QDEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/tip_engine.sv
// ----------------------------------------------------------------------------
// tip_engine
// Back end: breakpoint memories, binary search, linear interpolation with a
// radix-4 restoring divider, and the output register.
// ----------------------------------------------------------------------------
module tip_engine #(
    parameter int TABLE_DEPTH = tip_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = tip_pkg::DEF_VALUE_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tip_pkg::t_cmd                            i_cmd,
    input  logic                                     i_empty,
    output logic                                     o_pop,
    input  tip_pkg::t_cfg                            i_cfg,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [tip_pkg::PORT_VALUE_W-1:0]  o_y_result,
    output logic [2:0]                               o_status,
    output logic [tip_pkg::POS_W-1:0]                o_position
);
    import tip_pkg::*;

    localparam int VW = VALUE_BITS;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = NW + 1;
    localparam int MW = VW + 1;
    localparam int PW = 2 * MW;
    localparam int RW = VW + 3;
    localparam int CW = $clog2(VW + 2);
    localparam logic signed [RW-1:0] VMAX = {4'b0000, {(VW - 1){1'b1}}};
    localparam logic signed [RW-1:0] VMIN = {4'b1111, {(VW - 1){1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SRCH = 9'b000000010,
        S_CMP  = 9'b000000100,
        S_YRD  = 9'b000001000,
        S_LO   = 9'b000010000,
        S_HI   = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    // Breakpoint memories and their registered read data.
    logic signed [VW-1:0] x_mem [TABLE_DEPTH];
    logic signed [VW-1:0] y_mem [TABLE_DEPTH];
    logic signed [VW-1:0] r_xrd;
    logic signed [VW-1:0] r_yrd;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;

    t_state               r_state;
    logic signed [VW-1:0] r_x;
    logic signed [SW-1:0] r_low;
    logic signed [SW-1:0] r_high;
    logic signed [SW-1:0] r_mid;
    logic signed [SW-1:0] r_lo;
    logic signed [VW-1:0] r_xlo;
    logic signed [VW-1:0] r_ylo;
    logic [MW-1:0]        r_mdy;
    logic [MW-1:0]        r_mdq;
    logic [MW-1:0]        r_dx;
    logic                 r_neg;
    logic [MW-1:0]        r_rem;
    logic [PW-1:0]        r_dvd;
    logic [CW-1:0]        r_cnt;
    logic signed [VW-1:0] r_y;
    t_status              r_st;
    logic signed [SW-1:0] r_pos;

    logic                 r_ovalid;
    logic signed [VW-1:0] r_oy;
    t_status              r_ost;
    logic [POS_W-1:0]     r_opos;

    logic [NW-1:0]        n_pts;
    logic signed [SW-1:0] n_s;
    logic signed [SW-1:0] mid;
    logic signed [SW-1:0] lo_sel;
    logic signed [SW-1:0] end_idx;
    logic                 found_none;
    logic                 at_end;
    logic                 load_ok;
    logic signed [VW:0]   dx;
    logic signed [VW:0]   dy;
    logic signed [VW:0]   dq;
    logic [MW-1:0]        n_rem;
    logic [PW-1:0]        n_dvd;
    logic                 q_big;
    logic [RW-1:0]        q_clamp;
    logic signed [RW-1:0] y_sum;

    // Number of breakpoints in use, clamped to at least two and to the table size.
    always_comb begin
        if (int'(i_cfg.num_points) < 2) begin
            n_pts = NW'(2);
        end else if (int'(i_cfg.num_points) > TABLE_DEPTH) begin
            n_pts = NW'(TABLE_DEPTH);
        end else begin
            n_pts = NW'(i_cfg.num_points);
        end
    end
    assign n_s = $signed({1'b0, n_pts});

    // Search step and segment selection.
    assign mid        = r_low + ((r_high - r_low) >>> 1);
    assign found_none = (r_low > r_high);
    assign at_end     = (r_low == SW'(0)) || (r_low == n_s);
    assign end_idx    = (r_low == SW'(0)) ? SW'(0) : (n_s - SW'(1));
    assign lo_sel     = (r_low == SW'(0)) ? SW'(0) :
                        (r_low == n_s) ? (n_s - SW'(2)) : (r_low - SW'(1));
    assign load_ok    = int'(i_cmd.idx) < TABLE_DEPTH;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign mem_we     = o_pop && !i_cmd.query && load_ok;

    // Read address of both memories.
    always_comb begin
        unique case (r_state)
            S_SRCH: begin
                if (!found_none) begin
                    rd_addr = AW'($unsigned(mid));
                end else if (at_end && i_cfg.clip_enable) begin
                    rd_addr = AW'($unsigned(end_idx));
                end else begin
                    rd_addr = AW'($unsigned(lo_sel));
                end
            end
            S_CMP:   rd_addr = AW'($unsigned(r_mid));
            S_LO:    rd_addr = AW'($unsigned(r_lo + SW'(1)));
            default: rd_addr = '0;
        endcase
    end

    // Table memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            x_mem[AW'(i_cmd.idx)] <= VW'(i_cmd.x);
            y_mem[AW'(i_cmd.idx)] <= VW'(i_cmd.y);
        end
        r_xrd <= x_mem[rd_addr];
        r_yrd <= y_mem[rd_addr];
    end

    // Segment differences once both ends are read.
    always_comb begin
        dx = (VW + 1)'(r_xrd) - (VW + 1)'(r_xlo);
        dy = (VW + 1)'(r_yrd) - (VW + 1)'(r_ylo);
        dq = (VW + 1)'(r_x) - (VW + 1)'(r_xlo);
    end

    // Two restoring division steps per cycle.
    always_comb begin
        logic [MW:0] trial;
        logic        qbit;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_dvd[PW-1]};
            qbit  = (trial >= {1'b0, r_dx});
            if (qbit) begin
                trial = trial - {1'b0, r_dx};
            end
            n_rem = trial[MW-1:0];
            n_dvd = {n_dvd[PW-2:0], qbit};
        end
    end

    // Final add before saturation; a huge quotient is clamped so the sum saturates anyway.
    always_comb begin
        q_big   = |r_dvd[PW-1:VW+1];
        q_clamp = q_big ? (RW'(1) << (VW + 1)) : RW'(r_dvd[VW:0]);
        y_sum   = r_neg ? (RW'(r_ylo) - $signed(q_clamp))
                        : (RW'(r_ylo) + $signed(q_clamp));
    end

    // Output register valid flag: set on hand-over, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ovalid || !i_stall)) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.query) begin
                        r_x     <= VW'(i_cmd.x);
                        r_low   <= SW'(0);
                        r_high  <= n_s - SW'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (!found_none) begin
                        r_mid   <= mid;
                        r_state <= S_CMP;
                    end else begin
                        r_pos <= r_low;
                        if (at_end && i_cfg.clip_enable) begin
                            r_st    <= ST_CLIP;
                            r_state <= S_YRD;
                        end else begin
                            r_st    <= at_end ? ST_EXTRAP : ST_INTERP;
                            r_lo    <= lo_sel;
                            r_state <= S_LO;
                        end
                    end
                end
                S_CMP: begin
                    priority if (r_xrd < r_x) begin
                        r_low   <= r_mid + SW'(1);
                        r_state <= S_SRCH;
                    end else if (r_xrd > r_x) begin
                        r_high  <= r_mid - SW'(1);
                        r_state <= S_SRCH;
                    end else begin
                        r_pos   <= r_mid;
                        r_st    <= ST_EXACT;
                        r_state <= S_YRD;
                    end
                end
                S_YRD: begin
                    r_y     <= r_yrd;
                    r_state <= S_OUT;
                end
                S_LO: begin
                    r_xlo   <= r_xrd;
                    r_ylo   <= r_yrd;
                    r_state <= S_HI;
                end
                S_HI: begin
                    if (dx == '0) begin
                        r_y     <= '0;
                        r_st    <= ST_ZSPAN;
                        r_state <= S_OUT;
                    end else begin
                        r_mdy   <= MW'($unsigned(dy[VW] ? -dy : dy));
                        r_mdq   <= MW'($unsigned(dq[VW] ? -dq : dq));
                        r_dx    <= MW'($unsigned(dx[VW] ? -dx : dx));
                        r_neg   <= dy[VW] ^ dq[VW] ^ dx[VW];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dvd   <= r_mdy * r_mdq;
                    r_rem   <= '0;
                    r_cnt   <= CW'(VW + 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        priority if (y_sum > VMAX) begin
                            r_y  <= VW'(VMAX);
                            r_st <= ST_SAT;
                        end else if (y_sum < VMIN) begin
                            r_y  <= VW'(VMIN);
                            r_st <= ST_SAT;
                        end else begin
                            r_y  <= VW'(y_sum);
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_rem <= n_rem;
                        r_dvd <= n_dvd;
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_oy     <= r_y;
                        r_ost    <= r_st;
                        r_opos   <= POS_W'($unsigned(r_pos));
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_y_result = PORT_VALUE_W'(r_oy);
    assign o_status   = r_ost;
    assign o_position = r_opos;

endmodule

// File: rtl/table_interp_1d_top.sv
// ----------------------------------------------------------------------------
// table_interp_1d_top
// Piecewise-linear lookup over a loaded breakpoint table, signed Q16.16.
// ----------------------------------------------------------------------------
// A load transfer (op 0) writes one x/y breakpoint. A query transfer (op 1)
// is started, then runs binary search steps (at most 7 steps for 64 points),
// each a table read and a compare; it then closes the search, reads the segment
// ends, multiplies, runs the radix-4 divider and hands over the result. Exact
// matches and clipped queries skip the segment read, multiply and divider.
// The single-read-port table memories set the search time and the divider
// sets the rest. A two-entry command queue lets transfers be taken while the
// engine works, and a finished result waits in the output register while the
// engine starts on the next command.
// ----------------------------------------------------------------------------
module table_interp_1d_top #(
    parameter int TABLE_DEPTH = tip_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = tip_pkg::DEF_VALUE_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [tip_pkg::PADDR_W-1:0]              paddr,
    input  logic [tip_pkg::PDATA_W-1:0]              pwdata,
    output logic [tip_pkg::PDATA_W-1:0]              prdata,
    output logic                                     pready,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic                                     i_op,
    input  logic [tip_pkg::INDEX_W-1:0]              i_entry_index,
    input  logic signed [tip_pkg::PORT_VALUE_W-1:0]  i_x_value,
    input  logic signed [tip_pkg::PORT_VALUE_W-1:0]  i_y_value,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [tip_pkg::PORT_VALUE_W-1:0]  o_y_result,
    output logic [2:0]                               o_status,
    output logic [tip_pkg::POS_W-1:0]                o_position
);
    import tip_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    t_cfg cfg;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_stall = full;

    // Front end: registers and classification.
    tip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_x_value     (i_x_value),
        .i_y_value     (i_y_value),
        .i_queue_full  (full),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_cfg         (cfg)
    );

    // Command queue.
    tip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // Search and interpolation engine.
    tip_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (queue_cmd),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_cfg      (cfg),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_y_result (o_y_result),
        .o_status   (o_status),
        .o_position (o_position)
    );

endmodule

// File: rtl/tip_checker.sv
// ----------------------------------------------------------------------------
// tip_checker
// Port-level checks of the table lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module tip_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     pready,
    input  logic                                     o_valid,
    input  logic                                     i_stall,
    input  logic signed [tip_pkg::PORT_VALUE_W-1:0]  o_y_result,
    input  logic [2:0]                               o_status,
    input  logic [tip_pkg::POS_W-1:0]                o_position
);
    import tip_pkg::*;

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // A stalled result transfer holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_y_result)
            && $stable(o_status) && $stable(o_position))
        else $error("stalled result changed");

    // Status is always a defined code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_ZSPAN))
        else $error("undefined status code");

    // A zero-span segment always reports zero.
    a_zspan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ZSPAN) |-> (o_y_result == '0))
        else $error("zero span with nonzero result");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind table_interp_1d_top tip_checker u_tip_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .pready     (pready),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_y_result (o_y_result),
    .o_status   (o_status),
    .o_position (o_position)
);

// File: test/table_interp_1d_top_tb.sv
// ----------------------------------------------------------------------------
// table_interp_1d_top_tb
// Self-checking testbench of the piecewise-linear table lookup block.
// ----------------------------------------------------------------------------
// The whole breakpoint table is loaded before the first query, so no query
// ever reads an entry that was never written. A scoreboard predicts every
// query result from its own copy of the table and registers. Both stream
// sides idle in random bursts. One long receiver hold-off fills the block.
// The configuration is changed only between phases, once the block is idle.
// ----------------------------------------------------------------------------
module table_interp_1d_top_tb;
    import tip_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;
    localparam int HOLD_CYCLES = 400;
    localparam longint VMAX    = 64'sd2147483647;
    localparam longint VMIN    = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] y;
        t_status            st;
        logic [6:0]         pos;
    } t_lookup;

    // Scoreboard: keeps the table copy, predicts queries, checks results.
    class lookup_board;
        logic signed [31:0] xt[DEPTH];
        logic signed [31:0] yt[DEPTH];
        logic [6:0]         npts = 7'd2;
        logic               clip = 1'b1;
        t_lookup            pending[$];
        int                 fails = 0;

        task report(string msg);
            $display("MISMATCH: %s", msg);
            fails++;
        endtask

        function logic [63:0] mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function t_lookup predict(logic signed [31:0] xq);
            t_lookup    res;
            longint     x, n, low, high, mid, lo, hi, dy, dq, dx, r;
            logic [63:0] q;
            bit         neg, hit;
            x = xq;
            n = npts;
            if (n < 2) n = 2;
            if (n > DEPTH) n = DEPTH;
            low = 0;
            high = n - 1;
            hit = 0;
            mid = 0;
            while (low <= high && !hit) begin
                mid = low + ((high - low) >>> 1);
                if (longint'(xt[mid]) < x) low = mid + 1;
                else if (longint'(xt[mid]) > x) high = mid - 1;
                else hit = 1;
            end
            if (hit) begin
                res.y = yt[mid];
                res.st = ST_EXACT;
                res.pos = mid[6:0];
                return res;
            end
            res.pos = low[6:0];
            if (low == 0 || low == n) begin
                if (clip) begin
                    res.y = (low == 0) ? yt[0] : yt[n-1];
                    res.st = ST_CLIP;
                    return res;
                end
                lo = (low == 0) ? 0 : n - 2;
                res.st = ST_EXTRAP;
            end else begin
                lo = low - 1;
                res.st = ST_INTERP;
            end
            hi = lo + 1;
            if (xt[hi] == xt[lo]) begin
                res.y = '0;
                res.st = ST_ZSPAN;
                return res;
            end
            dy = longint'(yt[hi]) - longint'(yt[lo]);
            dq = x - longint'(xt[lo]);
            dx = longint'(xt[hi]) - longint'(xt[lo]);
            q = (mag(dy) * mag(dq)) / mag(dx);
            if (q > 64'd1 << 40) q = 64'd1 << 40;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            r = neg ? longint'(yt[lo]) - longint'(q) : longint'(yt[lo]) + longint'(q);
            if (r > VMAX) begin
                r = VMAX;
                res.st = ST_SAT;
            end
            if (r < VMIN) begin
                r = VMIN;
                res.st = ST_SAT;
            end
            res.y = r[31:0];
            return res;
        endfunction

        // Note one accepted input transfer.
        function void note(t_op op, logic [5:0] idx, logic signed [31:0] x,
                           logic signed [31:0] y);
            if (op == OP_LOAD) begin
                xt[idx] = x;
                yt[idx] = y;
            end else begin
                pending.push_back(predict(x));
            end
        endfunction

        // Check one accepted result transfer against the oldest prediction.
        task check(logic signed [31:0] y, logic [2:0] st, logic [6:0] pos);
            t_lookup e;
            if (pending.size() == 0) begin
                report("result with no query outstanding");
                return;
            end
            e = pending.pop_front();
            if (y !== e.y || st !== e.st || pos !== e.pos)
                report($sformatf("got y=%h st=%0d pos=%0d, want y=%h st=%0d pos=%0d",
                                 y, st, pos, e.y, e.st, e.pos));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid, o_stall, i_op;
    logic [INDEX_W-1:0] i_entry_index;
    logic signed [31:0] i_x_value, i_y_value;
    logic               o_valid, i_stall;
    logic signed [31:0] o_y_result;
    logic [2:0]         o_status;
    logic [POS_W-1:0]   o_position;

    lookup_board board = new();
    bit  quiet = 0;
    bit  hold_go = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    int  burst_left = 0;
    int  cycles = 0;

    table_interp_1d_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then choose the stall for next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) board.check(o_y_result, o_status, o_position);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 8);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one input transfer and wait until it is taken.
    task send(t_op op, logic [5:0] idx, logic signed [31:0] x, logic signed [31:0] y);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_entry_index <= idx;
        i_x_value <= x;
        i_y_value <= y;
        do @(posedge i_clk); while (o_stall);
        board.note(op, idx, x, y);
    endtask

    // Wait until every query is answered and the engine has gone quiet.
    task drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task reg_write(t_reg r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (r == REG_NUM_POINTS) board.npts = v[6:0];
        else board.clip = v[0];
    endtask

    task configure(logic [31:0] n, logic [31:0] c);
        drain();
        reg_write(REG_NUM_POINTS, n);
        @(posedge i_clk);
        reg_write(REG_CLIP_ENABLE, c);
        @(posedge i_clk);
    endtask

    // Load all entries with a fresh table: mostly sorted, sometimes repeats or noise.
    task load_table();
        logic signed [31:0] x0, step;
        longint             xv;
        int                 kind;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: step = $urandom_range(1, 4);
            1: step = $urandom_range(1, 65536 * 4);
            2: step = $urandom_range(1, 32'h03ff_ffff);
            default: step = $urandom_range(1, 32'h0200_0000);
        endcase
        xv = VMIN + longint'($urandom_range(0, 32'h7fff_ffff));
        if (xv + 64 * longint'(step) > VMAX) xv = VMAX - 64 * longint'(step);
        for (int i = 0; i < DEPTH; i++) begin
            if (kind == 0) begin
                x0 = $urandom;
            end else begin
                x0 = xv[31:0];
                if (!(kind == 1 && $urandom_range(0, 3) == 0)) xv = xv + step;
            end
            send(OP_LOAD, i[5:0], x0,
                 ($urandom_range(0, 2) == 0) ? $signed($urandom_range(0, 65536 * 8)) - 32'sd262144
                                             : $signed($urandom));
        end
    endtask

    // A query x drawn near the table contents or anywhere.
    function logic signed [31:0] pick_x();
        int k;
        k = $urandom_range(0, DEPTH - 1);
        case ($urandom_range(0, 4))
            0: return board.xt[k];
            1: return board.xt[k] + $signed($urandom_range(0, 300)) - 32'sd150;
            2: return board.xt[k] + $signed($urandom_range(0, 32'h00ff_ffff));
            3: return ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] nset[8];
        logic [31:0] cset[8];
        int          k;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_op <= OP_LOAD;
        i_entry_index <= '0;
        i_x_value <= '0;
        i_y_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme ends, even spacing, a repeated x pair at 10 and 11.
        for (int i = 0; i < DEPTH; i++)
            send(OP_LOAD, i[5:0], 32'sh8000_0000 + i * 32'sh0400_0000,
                 i[0] ? 32'sh7fff_ffff : 32'sh8000_0000);
        send(OP_LOAD, 6'd63, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send(OP_LOAD, 6'd11, 32'sh8000_0000 + 10 * 32'sh0400_0000, 32'sd5);
        send(OP_QUERY, 6'd0, 32'sh8000_0000, 32'sh7fff_ffff);
        send(OP_QUERY, 6'd0, 32'sh7fff_ffff, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sd0, 32'sd0);
        configure(64, 1);
        send(OP_QUERY, 6'd0, 32'sh8000_0000, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh7fff_ffff, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh8000_0000 + 32'sh0200_0000, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh8000_0000 + 10 * 32'sh0400_0000 + 32'sd7, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh8000_0000 + 11 * 32'sh0400_0000 - 32'sd7, 32'sd0);
        configure(20, 0);
        send(OP_QUERY, 6'd0, 32'sh8000_0000, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh7fff_ffff, 32'sd0);
        send(OP_QUERY, 6'd0, 32'sh0000_1234, 32'sd0);
        configure(0, 1);
        send(OP_QUERY, 6'd0, 32'sh7fff_ffff, 32'sd0);
        configure(127, 0);
        send(OP_QUERY, 6'd0, 32'sh8000_0001, 32'sd0);

        // Random phases over several settings, extremes first.
        nset = '{64, 64, 2, 2, 0, 127, 0, 0};
        cset = '{1, 0, 0, 1, 0, 1, 0, 0};
        for (int p = 0; p < 8; p++) begin
            if (p >= 6) begin
                nset[p] = $urandom_range(2, 64);
                cset[p] = $urandom_range(0, 1);
            end
            configure(nset[p], cset[p]);
            if (p == 7) quiet = 1;
            load_table();
            if (p == 1) hold_go = 1;
            for (int i = 0; i < 150; i++) begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    send(OP_LOAD, 6'($urandom_range(0, 63)), $urandom, $urandom);
                else if (k == 1)
                    send(OP_LOAD, 6'($urandom_range(0, 63)), pick_x(), $urandom);
                else
                    send(OP_QUERY, 6'($urandom_range(0, 63)), pick_x(), $urandom);
            end
        end

        drain();
        if (board.fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
